// ===== rtl/three_queue_burst_round_robin_assert.svh =====
// Assertion macros shared by the three-queue round-robin RTL.
// Needs clk and rst_n in scope at the point of use.
`ifndef THREE_QUEUE_BURST_ROUND_ROBIN_ASSERT_SVH
`define THREE_QUEUE_BURST_ROUND_ROBIN_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle check, clocked on clk, off while in reset.
`define TQB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition this cycle implies consequence next cycle.
`define TQB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TQB_ASSERT(lbl, prop, msg)
`define TQB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/tqbrr_pkg.sv =====
// Package for the three-queue burst round-robin block: constants, codes, types.
// No dependencies.
`default_nettype none

package tqbrr_pkg;

    localparam int NUM_ROADS       = 3;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 48;
    localparam int VEH_W           = 32;
    localparam int ROAD_W          = 2;
    localparam int KIND_W          = 2;
    localparam int BURST_W         = 4;
    localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

    localparam logic [BURST_W-1:0] BURST_RESET = 4'd3;

    localparam logic REQ_ENQUEUE = 1'b0;
    localparam logic REQ_DRAIN   = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ENQ   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    localparam logic [ROAD_W-1:0] ROAD_NONE = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENQ_RESP,
        ST_EMPTY_RESP,
        ST_DRAIN_STEP,
        ST_DRAIN_DATA
    } state_t;

    // One result to load into the output register.
    typedef struct packed {
        logic              load;
        logic [KIND_W-1:0] kind;
        logic              accepted;
        logic [ROAD_W-1:0] from_road;
        logic              last;
    } out_load_t;

    function automatic logic [ROAD_W-1:0] road_after(input logic [ROAD_W-1:0] r);
        logic [ROAD_W-1:0] n;
        n = (r == ROAD_W'(NUM_ROADS - 1)) ? '0 : r + 1'b1;
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tqbrr_store.sv =====
// Vehicle store: one single-port RAM holding all three road FIFOs back to back.
// Uses tqbrr_pkg for the word width.
`default_nettype none

module tqbrr_store #(
    parameter int WORDS  = 48,
    parameter int ADDR_W = 6
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic                         re,
    input  wire logic [ADDR_W-1:0]            addr,
    input  wire logic [tqbrr_pkg::VEH_W-1:0]  wdata,
    output logic      [tqbrr_pkg::VEH_W-1:0]  rdata
);

    logic [tqbrr_pkg::VEH_W-1:0] mem [WORDS];
    logic [tqbrr_pkg::VEH_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/tqbrr_seq.sv =====
// Sequencer: per-road head/tail/occupancy, one pointer update unit, drain loop.
// Uses tqbrr_pkg and three_queue_burst_round_robin_assert.svh.
`default_nettype none

`include "three_queue_burst_round_robin_assert.svh"

module tqbrr_seq #(
    parameter int QUEUE_DEPTH = tqbrr_pkg::QUEUE_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(tqbrr_pkg::NUM_ROADS * QUEUE_DEPTH)
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             req_type,
    input  wire logic [tqbrr_pkg::ROAD_W-1:0]     road,
    input  wire logic [tqbrr_pkg::BURST_W-1:0]    burst_limit,
    input  wire logic                             slot_free,
    output logic                                  mem_we,
    output logic                                  mem_re,
    output logic      [ADDR_W-1:0]                mem_addr,
    output tqbrr_pkg::out_load_t                  load
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TOT_W = $clog2(tqbrr_pkg::NUM_ROADS * QUEUE_DEPTH + 1);
    localparam int NR    = tqbrr_pkg::NUM_ROADS;

    tqbrr_pkg::state_t state_reg, state_next;

    logic [PTR_W-1:0] head_reg [NR];
    logic [PTR_W-1:0] head_next [NR];
    logic [PTR_W-1:0] tail_reg [NR];
    logic [PTR_W-1:0] tail_next [NR];
    logic [OCC_W-1:0] occ_reg [NR];
    logic [OCC_W-1:0] occ_next [NR];
    logic [TOT_W-1:0] total_reg, total_next;

    logic [tqbrr_pkg::ROAD_W-1:0]  cur_reg, cur_next;
    logic [tqbrr_pkg::BURST_W-1:0] served_reg, served_next;
    logic [tqbrr_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                          ok_reg, ok_next;
    logic                          last_reg, last_next;

    // Shared pointer unit: one road selected per cycle
    logic [tqbrr_pkg::ROAD_W-1:0]  sel;
    logic                          sel_ok;
    logic [PTR_W-1:0]              head_sel, tail_sel, ptr_sel, ptr_inc;
    logic [OCC_W-1:0]              occ_sel;
    logic [ADDR_W-1:0]             base;
    logic [tqbrr_pkg::BURST_W-1:0] limit;
    logic                          enq_ok;

    always_comb
    begin
        sel      = (state_reg == tqbrr_pkg::ST_IDLE) ? road : cur_reg;
        sel_ok   = (sel != tqbrr_pkg::ROAD_NONE);
        head_sel = sel_ok ? head_reg[sel] : '0;
        tail_sel = sel_ok ? tail_reg[sel] : '0;
        occ_sel  = sel_ok ? occ_reg[sel] : '0;
        ptr_sel  = (state_reg == tqbrr_pkg::ST_IDLE) ? tail_sel : head_sel;
        ptr_inc  = (ptr_sel == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_sel + 1'b1;
        base     = ADDR_W'(sel) * ADDR_W'(QUEUE_DEPTH);
        mem_addr = base + ADDR_W'(ptr_sel);
        limit    = (burst_limit == '0) ? tqbrr_pkg::BURST_W'(1) : burst_limit;
        enq_ok   = sel_ok && (occ_sel != OCC_W'(QUEUE_DEPTH));
    end

    assign in_stall = (state_reg != tqbrr_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tqbrr_pkg::ST_IDLE;
            total_reg  <= '0;
            cur_reg    <= '0;
            served_reg <= '0;
            count_reg  <= '0;
            ok_reg     <= 1'b0;
            last_reg   <= 1'b0;
            for (int i = 0; i < NR; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                occ_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            cur_reg    <= cur_next;
            served_reg <= served_next;
            count_reg  <= count_next;
            ok_reg     <= ok_next;
            last_reg   <= last_next;
            for (int i = 0; i < NR; i++)
            begin
                head_reg[i] <= head_next[i];
                tail_reg[i] <= tail_next[i];
                occ_reg[i]  <= occ_next[i];
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        total_next  = total_reg;
        cur_next    = cur_reg;
        served_next = served_reg;
        count_next  = count_reg;
        ok_next     = ok_reg;
        last_next   = last_reg;
        for (int i = 0; i < NR; i++)
        begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
            occ_next[i]  = occ_reg[i];
        end
        mem_we = 1'b0;
        mem_re = 1'b0;
        load   = '0;

        case (state_reg)
            tqbrr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == tqbrr_pkg::REQ_ENQUEUE)
                    begin
                        ok_next = enq_ok;
                        if (enq_ok)
                        begin
                            mem_we         = 1'b1;
                            tail_next[sel] = ptr_inc;
                            occ_next[sel]  = occ_sel + 1'b1;
                            total_next     = total_reg + 1'b1;
                        end
                        state_next = tqbrr_pkg::ST_ENQ_RESP;
                    end
                    else if (total_reg == '0)
                    begin
                        state_next = tqbrr_pkg::ST_EMPTY_RESP;
                    end
                    else
                    begin
                        cur_next    = '0;
                        served_next = '0;
                        count_next  = '0;
                        state_next  = tqbrr_pkg::ST_DRAIN_STEP;
                    end
                end
            end

            tqbrr_pkg::ST_ENQ_RESP:
            begin
                if (slot_free)
                begin
                    load.load     = 1'b1;
                    load.kind     = tqbrr_pkg::KIND_ENQ;
                    load.accepted = ok_reg;
                    load.last     = 1'b1;
                    state_next    = tqbrr_pkg::ST_IDLE;
                end
            end

            tqbrr_pkg::ST_EMPTY_RESP:
            begin
                if (slot_free)
                begin
                    load.load  = 1'b1;
                    load.kind  = tqbrr_pkg::KIND_EMPTY;
                    load.last  = 1'b1;
                    state_next = tqbrr_pkg::ST_IDLE;
                end
            end

            tqbrr_pkg::ST_DRAIN_STEP:
            begin
                if ((occ_sel != '0) && (served_reg < limit))
                begin
                    mem_re         = 1'b1;
                    head_next[sel] = ptr_inc;
                    occ_next[sel]  = occ_sel - 1'b1;
                    total_next     = total_reg - 1'b1;
                    served_next    = served_reg + 1'b1;
                    count_next     = count_reg + 1'b1;
                    last_next      = (total_reg == TOT_W'(1)) ||
                                     (count_reg == tqbrr_pkg::CNT_W'(tqbrr_pkg::MAX_RESULTS - 1));
                    state_next     = tqbrr_pkg::ST_DRAIN_DATA;
                end
                else
                begin
                    // turn over: empty road or burst used up
                    cur_next    = tqbrr_pkg::road_after(cur_reg);
                    served_next = '0;
                end
            end

            tqbrr_pkg::ST_DRAIN_DATA:
            begin
                if (slot_free)
                begin
                    load.load      = 1'b1;
                    load.kind      = tqbrr_pkg::KIND_REL;
                    load.from_road = cur_reg;
                    load.last      = last_reg;
                    state_next     = last_reg ? tqbrr_pkg::ST_IDLE : tqbrr_pkg::ST_DRAIN_STEP;
                end
            end

            default:
            begin
                state_next = tqbrr_pkg::ST_IDLE;
            end
        endcase
    end

    `TQB_ASSERT(a_total_sum, total_reg == TOT_W'(occ_reg[0]) + TOT_W'(occ_reg[1]) + TOT_W'(occ_reg[2]), "total count out of step with road counts")
    `TQB_ASSERT(a_occ_bound, (occ_reg[0] <= OCC_W'(QUEUE_DEPTH)) && (occ_reg[1] <= OCC_W'(QUEUE_DEPTH)) && (occ_reg[2] <= OCC_W'(QUEUE_DEPTH)), "road occupancy above depth")
    `TQB_ASSERT(a_read_nonempty, mem_re |-> (sel_ok && (occ_sel != '0)), "read from empty road")
    `TQB_ASSERT_NEXT(a_drain_resume, (state_reg == tqbrr_pkg::ST_DRAIN_DATA) && slot_free && !last_reg, state_reg == tqbrr_pkg::ST_DRAIN_STEP, "drain did not resume after beat")

endmodule

`default_nettype wire

// ===== rtl/three_queue_burst_round_robin.sv =====
// Usage: three road FIFOs of vehicle ids, drained round robin with a burst limit.
// Input channel (in_valid/in_stall): req_type, road, vehicle. req_type 0 enqueues
//   vehicle on road; req_type 1 drains all roads, starting at road 0 every time.
// Output channel (out_valid/out_stall): one beat per result, last marks the final
//   beat of an input item. Enqueue gives one answer beat (accepted 0 when the road
//   is full or road is 3). A drain gives one beat per released vehicle, at most 48,
//   or a single empty beat when nothing is queued.
// Config: cfg_we/cfg_wdata set burst_limit (0 acts as 1); write only while idle.
// Sequence: an enqueue is accepted in idle; its answer is loaded from ST_ENQ_RESP
//   once the output register is free. A drain releases each vehicle through
//   ST_DRAIN_STEP, which updates pointers and reads the RAM, then ST_DRAIN_DATA,
//   which moves the RAM word to the output register. Each road turnover adds a pass
//   through ST_DRAIN_STEP. The single RAM port and the one pointer unit set this order.
// in_stall is high from accept until the item's last beat is in the output
//   register; the output register lets the next item be taken while that beat
//   still waits. When out_stall is high the beat holds and the sequencer waits.
// Reset: asynchronous, clears all road counts and pointers, burst_limit to 3.
//   The RAM contents are not cleared; no clearing pass is needed.
// Depends on tqbrr_pkg, tqbrr_seq, tqbrr_store.
`default_nettype none

module three_queue_burst_round_robin #(
    parameter int QUEUE_DEPTH = tqbrr_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic        [tqbrr_pkg::BURST_W-1:0]   cfg_wdata,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic                                   req_type,
    input  wire logic        [tqbrr_pkg::ROAD_W-1:0]    road,
    input  wire logic signed [tqbrr_pkg::VEH_W-1:0]     vehicle,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic             [tqbrr_pkg::KIND_W-1:0]    result_kind,
    output logic                                        accepted,
    output logic             [tqbrr_pkg::ROAD_W-1:0]    from_road,
    output logic signed      [tqbrr_pkg::VEH_W-1:0]     released_vehicle,
    output logic                                        last
);

    localparam int WORDS  = tqbrr_pkg::NUM_ROADS * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(WORDS);

    logic [tqbrr_pkg::BURST_W-1:0] burst_reg;

    logic                          out_valid_reg;
    logic [tqbrr_pkg::KIND_W-1:0]  kind_reg;
    logic                          accepted_reg;
    logic [tqbrr_pkg::ROAD_W-1:0]  road_reg;
    logic [tqbrr_pkg::VEH_W-1:0]   vehicle_reg;
    logic                          last_reg;

    logic                          slot_free;
    logic                          mem_we, mem_re;
    logic [ADDR_W-1:0]             mem_addr;
    logic [tqbrr_pkg::VEH_W-1:0]   mem_rdata;
    tqbrr_pkg::out_load_t          load;

    // Burst limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_reg <= tqbrr_pkg::BURST_RESET;
        end
        else if (cfg_we)
        begin
            burst_reg <= cfg_wdata;
        end
    end

    // Output register is free when empty or its beat leaves this cycle
    assign slot_free = !out_valid_reg || !out_stall;

    tqbrr_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .road        (road),
        .burst_limit (burst_reg),
        .slot_free   (slot_free),
        .mem_we      (mem_we),
        .mem_re      (mem_re),
        .mem_addr    (mem_addr),
        .load        (load)
    );

    tqbrr_store #(
        .WORDS  (WORDS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (vehicle),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Beat payload; the vehicle field is only nonzero on a released vehicle
    always_ff @(posedge clk)
    begin
        if (load.load)
        begin
            kind_reg     <= load.kind;
            accepted_reg <= load.accepted;
            road_reg     <= load.from_road;
            last_reg     <= load.last;
            vehicle_reg  <= (load.kind == tqbrr_pkg::KIND_REL) ? mem_rdata : '0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign result_kind      = kind_reg;
    assign accepted         = accepted_reg;
    assign from_road        = road_reg;
    assign released_vehicle = vehicle_reg;
    assign last             = last_reg;

endmodule

`default_nettype wire
